// ===== src/grid_peak_finder_3x3_top_macros.svh =====
// Assertion macros shared by the peak finder RTL.
`ifndef GRID_PEAK_FINDER_3X3_TOP_MACROS_SVH
`define GRID_PEAK_FINDER_3X3_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define GPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/gpf_pkg.sv =====
// Shared constants and types of the 3x3 grid peak finder.
`default_nettype none

package gpf_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_SIDE_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths of the ports.
    localparam int CFG_BITS   = 11;
    localparam int VALUE_BITS = 16;
    localparam int POS_BITS   = 10;
    localparam int TALLY_BITS = 18;

    // Side length after reset.
    localparam int SIDE_RESET = 1024;

    // The peak count saturates at the top of its field.
    localparam logic [TALLY_BITS-1:0] TALLY_MAX = '1;

    // Record kinds carried on the result channel.
    typedef enum logic [0:0] {
        KIND_PEAK  = 1'b0,
        KIND_TOTAL = 1'b1
    } t_kind;

endpackage

`default_nettype wire

// ===== src/grid_peak_finder_3x3_top.sv =====
// Top level of the 3x3 local-maximum finder over a square raster grid.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------
//  input    | in        | i_in_valid/o_in_stall | i_sample_value
//  result   | out       | o_out_valid/i_out_stall | o_record_kind, o_peak_value,
//           |           |                      | o_peak_row, o_peak_column,
//           |           |                      | o_total_peaks, o_last_of_grid
//  config   | in        | i_cfg_valid/o_cfg_ready | i_side_length
//
// One sample beat is taken per cycle while o_in_stall is low, and its records leave from the
// result register. The line-store read is registered at acceptance, and the window
// compare sits in front of the result register. A sample that yields both a peak and the
// total record holds the input while both are pending. Reset is synchronous and needs no
// clearing pass; the line stores are read before being written only in a grid's first two
// rows, where no peak is tested. A result stall backs up through the two stages to o_in_stall.
`default_nettype none

`include "grid_peak_finder_3x3_top_macros.svh"

module grid_peak_finder_3x3_top #(
    parameter int MAX_SIDE    = gpf_pkg::MAX_SIDE_DEF,
    parameter int SAMPLE_BITS = gpf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration write channel.
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [gpf_pkg::CFG_BITS-1:0]   i_side_length,
    // Sample channel.
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_sample_value,
    // Result channel.
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_record_kind,
    output logic signed [gpf_pkg::VALUE_BITS-1:0] o_peak_value,
    output logic [gpf_pkg::POS_BITS-1:0]        o_peak_row,
    output logic [gpf_pkg::POS_BITS-1:0]        o_peak_column,
    output logic [gpf_pkg::TALLY_BITS-1:0]      o_total_peaks,
    output logic                                o_last_of_grid
);

    localparam int RC_BITS  = $clog2(MAX_SIDE);
    localparam int CMP_BITS = (gpf_pkg::CFG_BITS > RC_BITS + 1) ?
                              gpf_pkg::CFG_BITS : RC_BITS + 1;
    localparam int VEXT     = (SAMPLE_BITS > gpf_pkg::VALUE_BITS) ?
                              SAMPLE_BITS : gpf_pkg::VALUE_BITS;
    localparam int PEXT     = (RC_BITS > gpf_pkg::POS_BITS) ? RC_BITS : gpf_pkg::POS_BITS;
    localparam int RESET_SIDE = (gpf_pkg::SIDE_RESET > MAX_SIDE) ?
                                MAX_SIDE : gpf_pkg::SIDE_RESET;
    localparam logic [RC_BITS-1:0]  RESET_LAST = RC_BITS'(RESET_SIDE - 1);
    localparam logic [CMP_BITS-1:0] MAX_SIDE_C = CMP_BITS'(MAX_SIDE);
    localparam logic [RC_BITS-1:0]  FIRST_INNER = RC_BITS'(2);

    // Handshakes.
    logic cfg_we;
    logic in_accept;
    logic out_take;
    logic a_adv;
    logic b_free;

    // Grid position of the next sample and the last index of a row.
    logic [RC_BITS-1:0] r_row;
    logic [RC_BITS-1:0] r_col;
    logic [RC_BITS-1:0] r_last_idx;
    logic [RC_BITS-1:0] n_row;
    logic [RC_BITS-1:0] n_col;
    logic [RC_BITS-1:0] n_last_idx;
    logic [CMP_BITS-1:0] cfg_side;
    logic               at_row_end;
    logic               at_grid_end;

    // Input stage.
    logic                          r_a_valid;
    logic signed [SAMPLE_BITS-1:0] r_a_sample;
    logic [RC_BITS-1:0]            r_a_row;
    logic [RC_BITS-1:0]            r_a_col;
    logic                          r_a_inner;
    logic                          r_a_last;

    // Line-store read data for the sample in the input stage.
    logic signed [SAMPLE_BITS-1:0] lb_upper;
    logic signed [SAMPLE_BITS-1:0] lb_lower;

    // 3x3 window, [row][column], column 2 newest.
    logic signed [SAMPLE_BITS-1:0] r_win [3][3];
    logic signed [SAMPLE_BITS-1:0] centre;
    logic                          is_peak;
    logic                          peak_hit;

    // Peak tally of the grid in progress.
    logic [gpf_pkg::TALLY_BITS-1:0] r_tally;
    logic [gpf_pkg::TALLY_BITS-1:0] n_tally;

    // Result stage: up to two pending records.
    logic                             r_b_peak;
    logic                             r_b_total;
    logic signed [gpf_pkg::VALUE_BITS-1:0] r_b_value;
    logic [gpf_pkg::POS_BITS-1:0]     r_b_row;
    logic [gpf_pkg::POS_BITS-1:0]     r_b_col;
    logic [gpf_pkg::TALLY_BITS-1:0]   r_b_tally;
    logic signed [VEXT-1:0]           value_ext;
    logic [PEXT-1:0]                  row_ext;
    logic [PEXT-1:0]                  col_ext;

    // Flow control between the stages.
    assign cfg_we      = i_cfg_valid & o_cfg_ready;
    assign o_cfg_ready = 1'b1;
    assign out_take    = o_out_valid & ~i_out_stall;
    assign b_free      = ~(r_b_peak | r_b_total) | (out_take & ~(r_b_peak & r_b_total));
    assign a_adv       = r_a_valid & b_free;
    assign o_in_stall  = r_a_valid & ~b_free;
    assign in_accept   = i_in_valid & ~o_in_stall;

    // Side length from the write data, clamped to the supported range.
    always_comb begin
        cfg_side = CMP_BITS'(i_side_length);
        if (cfg_side == '0) begin
            cfg_side = CMP_BITS'(1);
        end else if (cfg_side > MAX_SIDE_C) begin
            cfg_side = MAX_SIDE_C;
        end
        n_last_idx = RC_BITS'(cfg_side - CMP_BITS'(1));
    end

    // Raster position of the next sample.
    always_comb begin
        at_row_end  = (r_col == r_last_idx);
        at_grid_end = at_row_end && (r_row == r_last_idx);
        n_row = r_row;
        n_col = r_col + RC_BITS'(1);
        if (at_grid_end) begin
            n_row = '0;
            n_col = '0;
        end else if (at_row_end) begin
            n_row = r_row + RC_BITS'(1);
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_last_idx <= RESET_LAST;
        end else if (cfg_we) begin
            r_row      <= '0;
            r_col      <= '0;
            r_last_idx <= n_last_idx;
        end else if (in_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Input stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_sample <= i_sample_value;
            r_a_row    <= r_row;
            r_a_col    <= r_col;
            r_a_inner  <= (r_row >= FIRST_INNER) && (r_col >= FIRST_INNER);
            r_a_last   <= at_grid_end;
        end
    end

    // Line stores: read at acceptance, written when the sample moves on.
    gpf_line_buf #(
        .DEPTH (MAX_SIDE),
        .WIDTH (SAMPLE_BITS),
        .AW    (RC_BITS)
    ) u_line_buf (
        .i_clk      (i_clk),
        .i_rd_en    (in_accept),
        .i_rd_addr  (r_col),
        .i_wr_en    (a_adv),
        .i_wr_addr  (r_a_col),
        .i_wr_upper (lb_lower),
        .i_wr_lower (r_a_sample),
        .o_upper    (lb_upper),
        .o_lower    (lb_lower)
    );

    // Peak test on the window after the shift: the centre is the old middle-right cell.
    always_comb begin
        centre  = r_win[1][2];
        is_peak = (centre > r_win[0][1]) && (centre > r_win[0][2]) &&
                  (centre > lb_upper)    && (centre > r_win[1][1]) &&
                  (centre > lb_lower)    && (centre > r_win[2][1]) &&
                  (centre > r_win[2][2]) && (centre > r_a_sample);
        peak_hit = r_a_inner && is_peak;
    end

    // Window shift by one column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (a_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= lb_upper;
            r_win[1][2] <= lb_lower;
            r_win[2][2] <= r_a_sample;
        end
    end

    // Saturating peak tally, cleared at the end of each grid and on a side write.
    always_comb begin
        n_tally = r_tally;
        if (peak_hit && (r_tally != gpf_pkg::TALLY_MAX)) begin
            n_tally = r_tally + gpf_pkg::TALLY_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else if (cfg_we) begin
            r_tally <= '0;
        end else if (a_adv) begin
            r_tally <= r_a_last ? '0 : n_tally;
        end
    end

    // Result stage: peak record first, then the total record.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_peak  <= 1'b0;
            r_b_total <= 1'b0;
        end else if (a_adv) begin
            r_b_peak  <= peak_hit;
            r_b_total <= r_a_last;
        end else if (out_take) begin
            if (r_b_peak) begin
                r_b_peak <= 1'b0;
            end else begin
                r_b_total <= 1'b0;
            end
        end
    end

    // Field widths of the record ports.
    always_comb begin
        value_ext = VEXT'(centre);
        row_ext   = PEXT'(r_a_row - RC_BITS'(1));
        col_ext   = PEXT'(r_a_col - RC_BITS'(1));
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_value <= value_ext[gpf_pkg::VALUE_BITS-1:0];
            r_b_row   <= row_ext[gpf_pkg::POS_BITS-1:0];
            r_b_col   <= col_ext[gpf_pkg::POS_BITS-1:0];
            r_b_tally <= n_tally;
        end
    end

    // Result beat.
    always_comb begin
        o_out_valid = r_b_peak | r_b_total;
        if (r_b_peak) begin
            o_record_kind  = gpf_pkg::KIND_PEAK;
            o_peak_value   = r_b_value;
            o_peak_row     = r_b_row;
            o_peak_column  = r_b_col;
            o_total_peaks  = '0;
            o_last_of_grid = 1'b0;
        end else begin
            o_record_kind  = gpf_pkg::KIND_TOTAL;
            o_peak_value   = '0;
            o_peak_row     = '0;
            o_peak_column  = '0;
            o_total_peaks  = r_b_tally;
            o_last_of_grid = 1'b1;
        end
    end

    // Checks on the pipeline and the raster counters.
    `GPF_ASSERT_NEXT(a_peak_before_total, i_clk, i_rst_n,
        r_b_peak && r_b_total && out_take, r_b_total && !r_b_peak,
        "total record did not follow its peak record")
    `GPF_ASSERT_NOW(a_pos_in_grid, i_clk, i_rst_n,
        1'b1, (r_row <= r_last_idx) && (r_col <= r_last_idx),
        "raster position beyond the grid side")
    `GPF_ASSERT_NEXT(a_grid_wraps, i_clk, i_rst_n,
        in_accept && at_grid_end && !cfg_we, (r_row == '0) && (r_col == '0),
        "position did not return to the origin after the last sample")
    `GPF_ASSERT_NOW(a_stall_needs_item, i_clk, i_rst_n,
        o_in_stall, r_a_valid && o_out_valid,
        "input stalled with an empty pipeline")

endmodule

`default_nettype wire

// ===== src/gpf_line_buf.sv =====
// Two line stores that hold the previous two rows of the grid.
`default_nettype none

module gpf_line_buf #(
    parameter int DEPTH = gpf_pkg::MAX_SIDE_DEF,
    parameter int WIDTH = gpf_pkg::SAMPLE_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rd_en,
    input  wire logic [AW-1:0]           i_rd_addr,
    input  wire logic                    i_wr_en,
    input  wire logic [AW-1:0]           i_wr_addr,
    input  wire logic signed [WIDTH-1:0] i_wr_upper,
    input  wire logic signed [WIDTH-1:0] i_wr_lower,
    output logic signed [WIDTH-1:0]      o_upper,
    output logic signed [WIDTH-1:0]      o_lower
);

    logic signed [WIDTH-1:0] r_upper_mem [DEPTH];
    logic signed [WIDTH-1:0] r_lower_mem [DEPTH];

    // Write port: the column's entries move up one row.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_upper_mem[i_wr_addr] <= i_wr_upper;
            r_lower_mem[i_wr_addr] <= i_wr_lower;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_upper <= r_upper_mem[i_rd_addr];
            o_lower <= r_lower_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the 3x3 grid peak finder with its own peak predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Field widths and limits taken over from the package.
    localparam int CFG_BITS     = gpf_pkg::CFG_BITS;
    localparam int VALUE_BITS   = gpf_pkg::VALUE_BITS;
    localparam int POS_BITS     = gpf_pkg::POS_BITS;
    localparam int TALLY_BITS   = gpf_pkg::TALLY_BITS;
    localparam int MAX_SIDE_DEF = gpf_pkg::MAX_SIDE_DEF;

    localparam int RAND_ITEMS   = 1780;
    localparam int DRAIN_CYCLES = 8;
    localparam int NEIGHBORS    = 8;
    localparam int REPORT_MAX   = 10;
    localparam int BIG_ITEMS    = 40;

    // One record on the result channel.
    typedef struct packed {
        gpf_pkg::t_kind         kind;
        logic signed [15:0]     value;
        logic [POS_BITS-1:0]    row;
        logic [POS_BITS-1:0]    col;
        logic [TALLY_BITS-1:0]  total;
        logic                   last;
    } t_peak_rec;

    // One row of the directed plan: a side write or a sample beat.
    // A negative n_typed means the records come from the predictor.
    typedef struct {
        bit          is_cfg;
        logic [15:0] data;
        int          n_typed;
        t_peak_rec   rec0;
        t_peak_rec   rec1;
    } t_step_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_BITS-1:0]           i_side_length = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic signed [VALUE_BITS-1:0]  i_sample_value = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic                          o_record_kind;
    logic signed [VALUE_BITS-1:0]  o_peak_value;
    logic [POS_BITS-1:0]           o_peak_row;
    logic [POS_BITS-1:0]           o_peak_column;
    logic [TALLY_BITS-1:0]         o_total_peaks;
    logic                          o_last_of_grid;

    grid_peak_finder_3x3_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_side_length  (i_side_length),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_record_kind  (o_record_kind),
        .o_peak_value   (o_peak_value),
        .o_peak_row     (o_peak_row),
        .o_peak_column  (o_peak_column),
        .o_total_peaks  (o_total_peaks),
        .o_last_of_grid (o_last_of_grid)
    );

    // Predictor state: line stores, window, scan position, tally and side.
    logic signed [15:0]     upper_line [MAX_SIDE_DEF];
    logic signed [15:0]     lower_line [MAX_SIDE_DEF];
    logic signed [15:0]     win [3][3];
    int unsigned            cur_row;
    int unsigned            cur_col;
    logic [TALLY_BITS-1:0]  tally;
    logic [CFG_BITS-1:0]    side_cfg;

    t_peak_rec              pending_records [$];
    t_step_row              plan [$];
    t_peak_rec              seen_rec;
    t_peak_rec              want_rec;
    int                     in_gap_pct = 33;
    int                     out_stall_pct = 61;
    int                     mismatches = 0;
    int                     records_checked = 0;
    int                     peaks_seen = 0;
    int                     totals_seen = 0;
    int                     samples_sent = 0;
    int                     side_writes = 0;
    int                     random_sent;
    int                     idx;
    int                     span;
    int                     n_items;
    int                     style;
    int                     pick;
    bit                     broken;
    bit                     first_grid;
    logic [CFG_BITS-1:0]    side_new;

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Random back-pressure on the result channel.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    function automatic t_peak_rec peak_rec(input logic signed [15:0] v,
                                           input logic [POS_BITS-1:0] r,
                                           input logic [POS_BITS-1:0] c);
        t_peak_rec rec;
        rec = '0;
        rec.kind  = gpf_pkg::KIND_PEAK;
        rec.value = v;
        rec.row   = r;
        rec.col   = c;
        return rec;
    endfunction

    function automatic t_peak_rec total_rec(input logic [TALLY_BITS-1:0] cnt);
        t_peak_rec rec;
        rec = '0;
        rec.kind  = gpf_pkg::KIND_TOTAL;
        rec.total = cnt;
        rec.last  = 1'b1;
        return rec;
    endfunction

    function automatic string fmt_rec(input t_peak_rec rec);
        return $sformatf("kind=%0d value=%0d row=%0d col=%0d total=%0d last=%0d",
                         rec.kind, rec.value, rec.row, rec.col, rec.total, rec.last);
    endfunction

    function automatic void restart_grid();
        cur_row = 0;
        cur_col = 0;
        tally   = '0;
    endfunction

    // Advance the predicted scan by one sample; returns the number of records it causes.
    function automatic int scan_sample(input logic signed [15:0] smp,
                                       output t_peak_rec rec0, output t_peak_rec rec1);
        int unsigned eff_side;
        int unsigned r;
        int unsigned c;
        int          n;
        int          beaten;
        int          i;
        int          j;
        eff_side = (side_cfg == 0) ? 1 :
                   (side_cfg > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(side_cfg);
        if (cur_row >= eff_side || cur_col >= eff_side) begin
            restart_grid();
        end
        r = cur_row;
        c = cur_col;

        // Slide the window and roll the line stores.
        for (i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = lower_line[c];
        win[2][2] = smp;
        upper_line[c] = lower_line[c];
        lower_line[c] = smp;

        n = 0;
        rec0 = '0;
        rec1 = '0;

        // The centre must beat all eight neighbors strictly.
        beaten = 0;
        for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3; j++) begin
                if (win[1][1] > win[i][j]) begin
                    beaten++;
                end
            end
        end
        if (r >= 2 && c >= 2 && beaten == NEIGHBORS) begin
            if (tally != gpf_pkg::TALLY_MAX) begin
                tally++;
            end
            rec0 = peak_rec(win[1][1], POS_BITS'(r - 1), POS_BITS'(c - 1));
            n = 1;
        end

        // The grid total follows any peak of the final window.
        if (r == eff_side - 1 && c == eff_side - 1) begin
            if (n == 0) begin
                rec0 = total_rec(tally);
            end else begin
                rec1 = total_rec(tally);
            end
            n++;
            restart_grid();
        end else if (c + 1 >= eff_side) begin
            cur_col = 0;
            cur_row = r + 1;
        end else begin
            cur_col = c + 1;
        end
        return n;
    endfunction

    function automatic t_step_row smp_row(input logic [15:0] v, input int n_typed,
                                          input t_peak_rec rec0, input t_peak_rec rec1);
        t_step_row row;
        row.is_cfg  = 1'b0;
        row.data    = v;
        row.n_typed = n_typed;
        row.rec0    = rec0;
        row.rec1    = rec1;
        return row;
    endfunction

    function automatic t_step_row cfg_row(input logic [CFG_BITS-1:0] s);
        t_step_row row;
        row = smp_row(16'(s), -1, '0, '0);
        row.is_cfg = 1'b1;
        return row;
    endfunction

    function automatic logic [15:0] pick_sample(input int kind_sel);
        case (kind_sel)
            0: return 16'($urandom);
            1: return 16'($urandom_range(4)) - 16'd2;
            2: begin
                case ($urandom_range(3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h8001;
                    default: return 16'h7ffe;
                endcase
            end
            default: return 16'($urandom_range(40)) + 16'hffec;
        endcase
    endfunction

    function automatic void set_idling(input int mode);
        case (mode)
            0: begin
                in_gap_pct    = 33;
                out_stall_pct = 61;
            end
            1: begin
                in_gap_pct    = 61;
                out_stall_pct = 33;
            end
            default: begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end
        endcase
    endfunction

    // Drive one sample beat, then queue the records it should cause.
    task automatic send_sample(input logic [15:0] v, input int n_typed,
                               input t_peak_rec t0, input t_peak_rec t1);
        t_peak_rec p0;
        t_peak_rec p1;
        int        n;
        while ($urandom_range(99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= v;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        n = scan_sample(v, p0, p1);
        if (n_typed >= 0) begin
            n  = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0) begin
            pending_records.push_back(p0);
        end
        if (n > 1) begin
            pending_records.push_back(p1);
        end
        samples_sent++;
    endtask

    // Let the block drain: all records in, then an idle wait so result-free beats leave the block.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_records.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_side(input logic [CFG_BITS-1:0] s);
        i_cfg_valid   <= 1'b1;
        i_side_length <= s;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        side_cfg = s;
        restart_grid();
        side_writes++;
    endtask

    // Check each accepted record against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_rec.kind  = gpf_pkg::t_kind'(o_record_kind);
            seen_rec.value = o_peak_value;
            seen_rec.row   = o_peak_row;
            seen_rec.col   = o_peak_column;
            seen_rec.total = o_total_peaks;
            seen_rec.last  = o_last_of_grid;
            records_checked++;
            if (seen_rec.kind == gpf_pkg::KIND_TOTAL) begin
                totals_seen++;
            end else begin
                peaks_seen++;
            end
            if (pending_records.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("Unexpected record at %0t: %s", $realtime, fmt_rec(seen_rec));
                end
            end else begin
                want_rec = pending_records.pop_front();
                if (seen_rec != want_rec) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("Mismatch at %0t: expected %s", $realtime, fmt_rec(want_rec));
                        $display("                 got      %s", fmt_rec(seen_rec));
                    end
                end
            end
        end
    end

    // Run-time limit.
    initial begin
        #5ms;
        $display("FAIL grid_peak_finder_3x3_top");
        $finish;
    end

    initial begin
        // Predictor reset.
        for (idx = 0; idx < MAX_SIDE_DEF; idx++) begin
            upper_line[idx] = '0;
            lower_line[idx] = '0;
        end
        for (idx = 0; idx < 9; idx++) begin
            win[idx / 3][idx % 3] = '0;
        end
        side_cfg = CFG_BITS'(gpf_pkg::SIDE_RESET);
        restart_grid();

        // Directed plan: side zero acts as one, so every sample closes a grid.
        plan.push_back(cfg_row(11'd0));
        plan.push_back(smp_row(16'h8000, 1, total_rec('0), '0));
        plan.push_back(smp_row(16'h7fff, 1, total_rec('0), '0));
        // An oversized side, with a grid dropped midway by the next write.
        plan.push_back(cfg_row(11'd2047));
        plan.push_back(smp_row(16'h1234, 0, '0, '0));
        // A side of two has no interior cells.
        plan.push_back(cfg_row(11'd2));
        plan.push_back(smp_row(16'h7fff, 0, '0, '0));
        plan.push_back(smp_row(16'h8000, 0, '0, '0));
        plan.push_back(smp_row(16'h5555, 0, '0, '0));
        plan.push_back(smp_row(16'haaaa, 1, total_rec('0), '0));
        // Side three: the peak sits in the last window, so it precedes the total.
        plan.push_back(cfg_row(11'd3));
        for (idx = 0; idx < 8; idx++) begin
            plan.push_back(smp_row((idx == 4) ? 16'h7fff : 16'h8000, -1, '0, '0));
        end
        plan.push_back(smp_row(16'h8000, 2, peak_rec(16'sh7fff, 10'd1, 10'd1),
                               total_rec(18'd1)));
        // A flat grid: equal neighbors never make a peak.
        for (idx = 0; idx < 8; idx++) begin
            plan.push_back(smp_row(16'd7, -1, '0, '0));
        end
        plan.push_back(smp_row(16'd7, 1, total_rec('0), '0));

        set_idling(0);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Side after reset: part of the first row, which yields no records.
        for (idx = 0; idx < BIG_ITEMS; idx++) begin
            send_sample(16'($urandom_range(65534)) + 16'h8000, -1, '0, '0);
        end

        foreach (plan[idx]) begin
            if (plan[idx].is_cfg) begin
                settle();
                write_side(plan[idx].data[CFG_BITS-1:0]);
            end else begin
                send_sample(plan[idx].data, plan[idx].n_typed, plan[idx].rec0, plan[idx].rec1);
            end
        end

        // Random grids, mostly complete, some cut short by a new side.
        random_sent = 0;
        first_grid  = 1'b1;
        while (random_sent < RAND_ITEMS) begin
            set_idling(random_sent * 3 / RAND_ITEMS);
            pick   = $urandom_range(99);
            broken = ($urandom_range(99) < 8);
            if (pick < 3) begin
                side_new = CFG_BITS'($urandom_range(1024, 2047));
                broken   = 1'b1;
            end else if (pick < 6) begin
                side_new = CFG_BITS'($urandom_range(1));
            end else if (pick < 10) begin
                side_new = 11'd2;
            end else if (pick < 88) begin
                side_new = CFG_BITS'($urandom_range(3, 8));
            end else begin
                side_new = CFG_BITS'($urandom_range(9, 20));
            end
            if (first_grid || broken || $urandom_range(3) != 0) begin
                settle();
                write_side(side_new);
            end
            first_grid = 1'b0;
            span = (side_cfg == 0) ? 1 :
                   (side_cfg > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(side_cfg);
            if (span == MAX_SIDE_DEF) begin
                n_items = $urandom_range(5, 40);
            end else if (broken && span > 1) begin
                n_items = $urandom_range(1, span * span - 1);
            end else begin
                n_items = span * span;
            end
            style = $urandom_range(3);
            for (idx = 0; idx < n_items; idx++) begin
                send_sample(pick_sample(style), -1, '0, '0);
                random_sent++;
            end
        end

        settle();
        $display("Sent %0d sample beats over %0d side writes (sides 0 to 2047).",
                 samples_sent, side_writes);
        $display("Checked %0d records: %0d peaks and %0d grid totals, %0d mismatches.",
                 records_checked, peaks_seen, totals_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASS grid_peak_finder_3x3_top");
        end else begin
            $display("FAIL grid_peak_finder_3x3_top");
        end
        $finish;
    end

endmodule
